[rtl/ale_pkg.sv]
// ----------------------------------------------------------------------------
// ale_pkg: shared types and constants for the array list engine
// Request and response payloads, operation and status codes, and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ale_pkg;

    // Default list capacity
    localparam int CAPACITY_DEF = 128;

    // Operation codes carried in the request
    typedef enum logic [2:0] {
        FN_INS_HEAD = 3'd0,
        FN_INS_TAIL = 3'd1,
        FN_FIND     = 3'd2,
        FN_READ     = 3'd3,
        FN_DEL_VAL  = 3'd4,
        FN_DEL_POS  = 3'd5
    } t_func;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } t_status;

    // Request item
    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] value;
        logic [7:0]         position;
    } t_req;

    // Response item
    typedef struct packed {
        logic [1:0]         status;
        logic [6:0]         found_index;
        logic signed [31:0] read_value;
        logic [7:0]         entry_total;
        logic               is_empty;
    } t_rsp;

    // Commands from the controller to the datapath, one per cycle
    typedef enum logic [4:0] {
        CMD_IDLE,
        CMD_LOAD,
        CMD_TAIL,
        CMD_SRCH_INIT,
        CMD_SRCH_STEP,
        CMD_FOUND,
        CMD_SHDN_POS,
        CMD_SHDN_MATCH,
        CMD_SHDN_STEP,
        CMD_DEL_FINISH,
        CMD_SHUP_INIT,
        CMD_SHUP_STEP,
        CMD_HEAD_FINISH,
        CMD_RD_ISSUE,
        CMD_RD_CAPTURE,
        CMD_SET_FULL,
        CMD_SET_MISS,
        CMD_EMIT
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        t_func func;
        logic  full;
        logic  pos_ok;
        logic  match;
        logic  scan_done;
        logic  shup_done;
    } t_dp_status;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SRCH,
        S_SHDN,
        S_SHUP,
        S_RDWAIT,
        S_DONE
    } t_state;

endpackage

[rtl/array_list_engine_top.sv]
// ----------------------------------------------------------------------------
// array_list_engine_top: packed ordered list of signed 32-bit values
// Find, deletes and head insert walk the store one entry per cycle over its
// single read port; append, read and requests rejected at decode need no
// walk. One item is in work at a time; the next is taken the cycle after
// the result is loaded into the output register.
// Reset clears the entry count; the store is not cleared and needs no
// clearing pass.
// ----------------------------------------------------------------------------
module array_list_engine_top import ale_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out
);

    t_dp_cmd    w_cmd;
    t_dp_status w_sts;

    ale_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    ale_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_req   (i_in),
        .o_sts   (w_sts),
        .o_rsp   (o_out)
    );

    // Stall straight after an item is taken
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall
    ) else $error("input not stalled after accepting an item");

    // A result appears only at the end of an item in work
    a_result_from_work: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall)
    ) else $error("result raised without an item in work");

    // Reset clears the output valid
    a_reset_clears_out: assert property (
        @(posedge i_clk)
        !i_rst_n |=> !o_out_valid
    ) else $error("output valid after reset");

endmodule

[rtl/ale_ram.sv]
// ----------------------------------------------------------------------------
// ale_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/ale_datapath.sv]
// ----------------------------------------------------------------------------
// ale_datapath: list store, entry count, scan pointers and result registers
// Executes one controller command per cycle. Scans and shifts issue one
// store read per cycle and act on the data in the cycle after.
// ----------------------------------------------------------------------------
module ale_datapath import ale_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  t_req       i_req,
    output t_dp_status o_sts,
    output t_rsp       o_rsp
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = CW + 8;

    // Request and result registers
    t_func              r_func,   n_func;
    logic signed [31:0] r_value,  n_value;
    logic [7:0]         r_pos,    n_pos;
    t_status            r_status, n_status;
    logic [CW-1:0]      r_found,  n_found;
    logic signed [31:0] r_rval,   n_rval;
    t_rsp               r_rsp,    n_rsp;

    // Count and scan registers
    logic [CW-1:0]      r_count,   n_count;
    logic [CW-1:0]      r_idx,     n_idx;
    logic               r_chk_vld, n_chk_vld;
    logic [CW-1:0]      r_chk_idx, n_chk_idx;

    // Store port signals
    logic               w_wr_en;
    logic [IW-1:0]      w_wr_addr;
    logic [31:0]        w_wr_data;
    logic [IW-1:0]      w_rd_addr;
    logic [31:0]        w_rd_data;

    // Derived values
    logic [XW-1:0]      w_pos_x;
    logic [XW-1:0]      w_cnt_x;
    logic [XW-1:0]      w_posm1;
    logic [CW-1:0]      w_idx_dn;
    logic [CW-1:0]      w_chk_m1;
    logic [CW-1:0]      w_chk_p1;
    logic               w_more;
    logic [CW+7:0]      w_cnt_wide;
    logic [CW+6:0]      w_found_wide;

    ale_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_pos_x      = {{CW{1'b0}}, r_pos};
    assign w_cnt_x      = {8'd0, r_count};
    assign w_posm1      = w_pos_x - XW'(1);
    assign w_idx_dn     = r_idx - CW'(1);
    assign w_chk_m1     = r_chk_idx - CW'(1);
    assign w_chk_p1     = r_chk_idx + CW'(1);
    assign w_more       = (r_idx < r_count);
    assign w_cnt_wide   = {8'd0, r_count};
    assign w_found_wide = {7'd0, r_found};

    // Status towards the controller
    assign o_sts.func      = r_func;
    assign o_sts.full      = (r_count == CW'(CAPACITY));
    assign o_sts.pos_ok    = (r_pos != 8'd0) && (w_pos_x <= w_cnt_x);
    assign o_sts.match     = r_chk_vld && (w_rd_data == r_value);
    assign o_sts.scan_done = !r_chk_vld && !w_more;
    assign o_sts.shup_done = !r_chk_vld && (r_idx == '0);

    // Decode the command into next values and store accesses
    always_comb begin
        n_func    = r_func;
        n_value   = r_value;
        n_pos     = r_pos;
        n_status  = r_status;
        n_found   = r_found;
        n_rval    = r_rval;
        n_rsp     = r_rsp;
        n_count   = r_count;
        n_idx     = r_idx;
        n_chk_vld = r_chk_vld;
        n_chk_idx = r_chk_idx;
        w_wr_en   = 1'b0;
        w_wr_addr = '0;
        w_wr_data = r_value;
        w_rd_addr = r_idx[IW-1:0];
        unique case (i_cmd)
            CMD_LOAD: begin
                n_func   = t_func'(i_req.func);
                n_value  = i_req.value;
                n_pos    = i_req.position;
                n_status = ST_OK;
                n_found  = '0;
                n_rval   = '0;
            end
            CMD_TAIL: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_count[IW-1:0];
                n_count   = r_count + CW'(1);
            end
            CMD_SRCH_INIT: begin
                n_idx     = '0;
                n_chk_vld = 1'b0;
            end
            CMD_SRCH_STEP: begin
                n_chk_vld = w_more;
                n_chk_idx = r_idx;
                if (w_more) begin
                    n_idx = r_idx + CW'(1);
                end
            end
            CMD_FOUND: begin
                n_found = r_chk_idx;
            end
            CMD_SHDN_POS: begin
                n_idx     = w_pos_x[CW-1:0];
                n_chk_vld = 1'b0;
            end
            CMD_SHDN_MATCH: begin
                n_idx     = w_chk_p1;
                n_chk_vld = 1'b0;
            end
            CMD_SHDN_STEP: begin
                // read the next entry, write the previous one a place lower
                n_chk_vld = w_more;
                n_chk_idx = r_idx;
                if (w_more) begin
                    n_idx = r_idx + CW'(1);
                end
                w_wr_en   = r_chk_vld;
                w_wr_addr = w_chk_m1[IW-1:0];
                w_wr_data = w_rd_data;
            end
            CMD_DEL_FINISH: begin
                n_count = r_count - CW'(1);
            end
            CMD_SHUP_INIT: begin
                n_idx     = r_count;
                n_chk_vld = 1'b0;
            end
            CMD_SHUP_STEP: begin
                // walk down from the tail, write each entry a place higher
                w_rd_addr = w_idx_dn[IW-1:0];
                n_chk_vld = (r_idx != '0);
                n_chk_idx = w_idx_dn;
                if (r_idx != '0) begin
                    n_idx = w_idx_dn;
                end
                w_wr_en   = r_chk_vld;
                w_wr_addr = w_chk_p1[IW-1:0];
                w_wr_data = w_rd_data;
            end
            CMD_HEAD_FINISH: begin
                w_wr_en   = 1'b1;
                w_wr_addr = '0;
                n_count   = r_count + CW'(1);
            end
            CMD_RD_ISSUE: begin
                w_rd_addr = w_posm1[IW-1:0];
            end
            CMD_RD_CAPTURE: begin
                n_rval = w_rd_data;
            end
            CMD_SET_FULL: begin
                n_status = ST_FULL;
            end
            CMD_SET_MISS: begin
                n_status = ST_MISS;
            end
            CMD_EMIT: begin
                n_rsp.status      = r_status;
                n_rsp.found_index = w_found_wide[6:0];
                n_rsp.read_value  = r_rval;
                n_rsp.entry_total = w_cnt_wide[7:0];
                n_rsp.is_empty    = (r_count == '0);
            end
            default: begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_chk_vld <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_chk_vld <= n_chk_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_value   <= n_value;
        r_pos     <= n_pos;
        r_status  <= n_status;
        r_found   <= n_found;
        r_rval    <= n_rval;
        r_rsp     <= n_rsp;
        r_idx     <= n_idx;
        r_chk_idx <= n_chk_idx;
    end

    assign o_rsp = r_rsp;

endmodule

[rtl/ale_ctrl.sv]
// ----------------------------------------------------------------------------
// ale_ctrl: sequencing state machine for the array list engine
// Takes one item at a time, steps the datapath through the operation and
// hands the result to the output register when it has room.
// ----------------------------------------------------------------------------
module ale_ctrl import ale_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    input  t_dp_status i_sts,
    output t_dp_cmd    o_cmd
);

    t_state  r_state, n_state;
    logic    r_out_vld, n_out_vld;
    logic    w_out_room;

    assign w_out_room = !r_out_vld || !i_out_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.func)
                    FN_INS_HEAD: n_state = i_sts.full ? S_DONE : S_SHUP;
                    FN_FIND, FN_DEL_VAL: n_state = S_SRCH;
                    FN_READ:     n_state = i_sts.pos_ok ? S_RDWAIT : S_DONE;
                    FN_DEL_POS:  n_state = i_sts.pos_ok ? S_SHDN : S_DONE;
                    default:     n_state = S_DONE;
                endcase
            end
            S_SRCH: begin
                priority if (i_sts.match) begin
                    n_state = (i_sts.func == FN_FIND) ? S_DONE : S_SHDN;
                end else if (i_sts.scan_done) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SRCH;
                end
            end
            S_SHDN: begin
                if (i_sts.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_SHUP: begin
                if (i_sts.shup_done) begin
                    n_state = S_DONE;
                end
            end
            S_RDWAIT: n_state = S_DONE;
            S_DONE: begin
                if (w_out_room) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath commands and input handshake
    always_comb begin
        o_cmd      = CMD_IDLE;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd = CMD_LOAD;
                end
            end
            S_DECODE: begin
                unique case (i_sts.func)
                    FN_INS_HEAD: o_cmd = i_sts.full ? CMD_SET_FULL : CMD_SHUP_INIT;
                    FN_INS_TAIL: o_cmd = i_sts.full ? CMD_SET_FULL : CMD_TAIL;
                    FN_FIND, FN_DEL_VAL: o_cmd = CMD_SRCH_INIT;
                    FN_READ:     o_cmd = i_sts.pos_ok ? CMD_RD_ISSUE : CMD_SET_MISS;
                    FN_DEL_POS:  o_cmd = i_sts.pos_ok ? CMD_SHDN_POS : CMD_SET_MISS;
                    default:     o_cmd = CMD_IDLE;
                endcase
            end
            S_SRCH: begin
                priority if (i_sts.match) begin
                    o_cmd = (i_sts.func == FN_FIND) ? CMD_FOUND : CMD_SHDN_MATCH;
                end else if (i_sts.scan_done) begin
                    o_cmd = CMD_SET_MISS;
                end else begin
                    o_cmd = CMD_SRCH_STEP;
                end
            end
            S_SHDN:   o_cmd = i_sts.scan_done ? CMD_DEL_FINISH : CMD_SHDN_STEP;
            S_SHUP:   o_cmd = i_sts.shup_done ? CMD_HEAD_FINISH : CMD_SHUP_STEP;
            S_RDWAIT: o_cmd = CMD_RD_CAPTURE;
            S_DONE: begin
                if (w_out_room) begin
                    o_cmd = CMD_EMIT;
                end
            end
            default: o_cmd = CMD_IDLE;
        endcase
    end

    // Output valid: set on emit, drop once taken
    always_comb begin
        n_out_vld = r_out_vld && i_out_stall;
        if (o_cmd == CMD_EMIT) begin
            n_out_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_out_valid = r_out_vld;

endmodule
